[rtl/rrlt_pkg.sv]
package rrlt_pkg;

    localparam int COORD_BITS = 32;

    localparam logic CMD_LOCK   = 1'b0;
    localparam logic CMD_UNLOCK = 1'b1;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_CONFLICT  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_UNLOCKED  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic       cmd;
        coord_t     left_x;
        coord_t     top_y;
        coord_t     right_x;
        coord_t     bottom_y;
        logic       want_write;
        logic [4:0] release_id;
    } rrlt_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] granted_id;
    } rrlt_rsp_t;

    // flags that ride down the cell chain
    typedef struct packed {
        logic clash;
        logic free_found;
        logic found;
    } rrlt_probe_t;

    // update strobes broadcast to every cell at the end of a request
    typedef struct packed {
        logic set;
        logic clr;
    } rrlt_commit_t;

    // closed-interval overlap, three-clause form; corners are not reordered
    function automatic logic spans_meet(coord_t lo, coord_t hi, coord_t rlo, coord_t rhi);
        logic a;
        logic b;
        logic c;
        a = (rlo >= lo) && (rlo <= hi);
        b = (rlo <= lo) && (rhi >= hi);
        c = (rhi >= lo) && (rhi <= hi);
        return a || b || c;
    endfunction

endpackage

[rtl/rrlt_cell.sv]
module rrlt_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rrlt_pkg::rrlt_req_t    req,
    input  rrlt_pkg::rrlt_probe_t  probe_in,
    input  logic [IDX_W-1:0]       free_idx_in,
    input  rrlt_pkg::rrlt_commit_t commit,
    input  logic [IDX_W-1:0]       commit_idx,
    output rrlt_pkg::rrlt_probe_t  probe_out,
    output logic [IDX_W-1:0]       free_idx_out
);
    import rrlt_pkg::*;

    localparam int RID_W = IDX_W + 6;

    logic        valid_reg;
    logic        is_write_reg;
    coord_t      left_x_reg;
    coord_t      top_y_reg;
    coord_t      right_x_reg;
    coord_t      bottom_y_reg;

    rrlt_probe_t      probe_reg;
    rrlt_probe_t      probe_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;

    logic own_clash;
    logic rid_match;
    logic set_here;

    assign rid_match = (RID_W'(req.release_id) == RID_W'(IDX + 1));
    assign set_here  = commit.set && (commit_idx == IDX_W'(IDX));

    assign own_clash = valid_reg && (is_write_reg || req.want_write)
                    && spans_meet(left_x_reg, right_x_reg, req.left_x, req.right_x)
                    && spans_meet(top_y_reg, bottom_y_reg, req.top_y, req.bottom_y);

    always_comb
    begin
        probe_next.clash = probe_in.clash | own_clash;
        probe_next.found = probe_in.found | (valid_reg && rid_match);
        if (!probe_in.free_found && !valid_reg)
        begin
            probe_next.free_found = 1'b1;
            free_idx_next         = IDX_W'(IDX);
        end
        else
        begin
            probe_next.free_found = probe_in.free_found;
            free_idx_next         = free_idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (set_here)
            begin
                valid_reg <= 1'b1;
            end
            else if (commit.clr && rid_match)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        if (set_here)
        begin
            is_write_reg <= req.want_write;
            left_x_reg   <= req.left_x;
            top_y_reg    <= req.top_y;
            right_x_reg  <= req.right_x;
            bottom_y_reg <= req.bottom_y;
        end
    end

    assign probe_out    = probe_reg;
    assign free_idx_out = free_idx_reg;

endmodule

[rtl/rectangle_region_lock_table.sv]
// Rectangle lock table with shared (read) and exclusive (write) locks.
// A lock beat names a rectangle by its corners; it is granted the lowest
// free id (slot + 1) unless it overlaps a held lock where either side is a
// write lock, in which case status is conflict (checked before table full).
// An unlock beat frees release_id and says whether it was held. Each slot is
// one cell in a chain; the probe walks one cell per clock, and the response
// is registered once the probe has passed every cell and the previous
// response has been taken or is being taken. One request is in flight at a
// time; a new one can be taken while the previous response is still waiting.
module rectangle_region_lock_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rrlt_pkg::rrlt_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rrlt_pkg::rrlt_rsp_t rsp
);
    import rrlt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int GID_W = IDX_W + 6;

    // request held stable while the probe walks the chain
    rrlt_req_t       req_reg;
    logic            busy_reg;
    logic            busy_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rrlt_rsp_t rsp_reg;
    rrlt_rsp_t rsp_next;

    rrlt_probe_t      chain_probe [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] chain_idx   [TABLE_ENTRIES+1];

    rrlt_commit_t commit;
    logic         accept;
    logic         done;
    rrlt_probe_t  tail;
    logic [IDX_W-1:0] tail_idx;
    logic [GID_W-1:0] gid_wide;

    assign chain_probe[0] = '0;
    assign chain_idx[0]   = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        rrlt_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .req          (req_reg),
            .probe_in     (chain_probe[i]),
            .free_idx_in  (chain_idx[i]),
            .commit       (commit),
            .commit_idx   (tail_idx),
            .probe_out    (chain_probe[i+1]),
            .free_idx_out (chain_idx[i+1])
        );
    end

    assign tail     = chain_probe[TABLE_ENTRIES];
    assign tail_idx = chain_idx[TABLE_ENTRIES];
    assign gid_wide = GID_W'(tail_idx) + GID_W'(1);

    assign req_stall = busy_reg;
    assign accept    = req_valid && !busy_reg;

    // chain has settled once the probe has passed every cell since the request register loaded
    assign done = busy_reg && (count_reg == CNT_W'(TABLE_ENTRIES))
               && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        commit     = '0;
        rsp_next   = rsp_reg;
        busy_next  = busy_reg;
        count_next = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (accept)
        begin
            busy_next  = 1'b1;
            count_next = '0;
        end
        else if (busy_reg && (count_reg != CNT_W'(TABLE_ENTRIES)))
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (done)
        begin
            busy_next           = 1'b0;
            rsp_valid_next      = 1'b1;
            rsp_next.granted_id = '0;
            if (req_reg.cmd == CMD_UNLOCK)
            begin
                commit.clr      = tail.found;
                rsp_next.status = tail.found ? ST_UNLOCKED : ST_NOT_FOUND;
            end
            else if (tail.clash)
            begin
                rsp_next.status = ST_CONFLICT;
            end
            else if (!tail.free_found)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                commit.set          = 1'b1;
                rsp_next.status     = ST_GRANTED;
                rsp_next.granted_id = gid_wide[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg <= req;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[tb/sv/tb_rectangle_region_lock_table.sv]
module tb_rectangle_region_lock_table;

    timeunit 1ns;
    timeprecision 1ps;

    import rrlt_pkg::*;

    localparam int          SLOTS        = 16;
    localparam int          RANDOM_BEATS = 1600;
    localparam int          DRAIN_CYCLES = 40;        // quiet tail after the last answer
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Block ports; every input starts at a known value
    logic      req_valid = 1'b0;
    logic      req_stall;
    rrlt_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rrlt_rsp_t rsp;

    rectangle_region_lock_table #(
        .TABLE_ENTRIES(SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // Lock table mirror. A slot's rectangle is only looked at while the
    // slot is held, same as in the block.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic   is_write;
        coord_t lx;
        coord_t ty;
        coord_t rx;
        coord_t by;
    } held_rect_t;

    bit         slot_held [SLOTS];
    held_rect_t slot_rect [SLOTS];

    rrlt_req_t pending_reqs[$];       // beats not yet driven
    rrlt_rsp_t expected_answers[$];   // answers owed by the block, oldest first

    int mismatch_count = 0;
    int lock_beats     = 0;
    int unlock_beats   = 0;
    int answer_tally [8];
    int unsigned cycle_count = 0;

    // Closed-interval overlap: held span [lo,hi], requested span [rlo,rhi].
    // Corners are taken as given, so an inverted held span can only meet
    // through the middle clause.
    function automatic bit spans_touch(coord_t lo, coord_t hi, coord_t rlo, coord_t rhi);
        return ((rlo >= lo) && (rlo <= hi)) ||
               ((rlo <= lo) && (rhi >= hi)) ||
               ((rhi >= lo) && (rhi <= hi));
    endfunction

    // Applies one accepted beat to the mirror and returns the answer it owes.
    function automatic rrlt_rsp_t lock_table_answer(rrlt_req_t r);
        rrlt_rsp_t a;
        bit        clash;
        int        free_slot;
        int        slot;
        a.status     = ST_NOT_FOUND;
        a.granted_id = '0;
        if (r.cmd == CMD_UNLOCK)
        begin
            slot = int'(r.release_id) - 1;
            if (slot >= 0 && slot < SLOTS)
            begin
                if (slot_held[slot])
                begin
                    slot_held[slot] = 1'b0;
                    a.status        = ST_UNLOCKED;
                end
            end
        end
        else
        begin
            clash     = 1'b0;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_held[i])
                begin
                    if ((slot_rect[i].is_write || r.want_write) &&
                        spans_touch(slot_rect[i].lx, slot_rect[i].rx, r.left_x, r.right_x) &&
                        spans_touch(slot_rect[i].ty, slot_rect[i].by, r.top_y, r.bottom_y))
                        clash = 1'b1;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            // conflict wins over a full table
            if (clash)
                a.status = ST_CONFLICT;
            else if (free_slot < 0)
                a.status = ST_FULL;
            else
            begin
                slot_held[free_slot] = 1'b1;
                slot_rect[free_slot] = '{r.want_write, r.left_x, r.top_y, r.right_x, r.bottom_y};
                a.status             = ST_GRANTED;
                a.granted_id         = 5'(free_slot + 1);
            end
        end
        return a;
    endfunction

    // Idle length for either side: mostly none or short, now and then long
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic queue_lock(logic wr, coord_t lx, coord_t ty, coord_t rx, coord_t by);
        rrlt_req_t r;
        r.cmd        = CMD_LOCK;
        r.left_x     = lx;
        r.top_y      = ty;
        r.right_x    = rx;
        r.bottom_y   = by;
        r.want_write = wr;
        r.release_id = 5'($urandom_range(0, 31));   // ignored on a lock beat
        pending_reqs.push_back(r);
    endtask

    task automatic queue_unlock(int unsigned id);
        rrlt_req_t r;
        r.cmd        = CMD_UNLOCK;
        r.left_x     = $urandom;                     // coordinates ignored on unlock
        r.top_y      = $urandom;
        r.right_x    = $urandom;
        r.bottom_y   = $urandom;
        r.want_write = 1'($urandom_range(0, 1));
        r.release_id = 5'(id);
        pending_reqs.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Request driver: one beat at a time from pending_reqs, held while
    // stalled, with random idle cycles after each accepted beat. The
    // mirror is updated on the accepting edge, in accept order.
    // ------------------------------------------------------------------
    int unsigned send_wait = 0;
    int unsigned send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_answers.push_back(lock_table_answer(req));
                if (req.cmd == CMD_UNLOCK)
                    unlock_beats++;
                else
                    lock_beats++;
            end
            if (!req_valid || !req_stall)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    // calm stretches give back-to-back beats
                    if (send_calm != 0)
                    begin
                        send_calm--;
                        send_wait = 0;
                    end
                    else if ($urandom_range(0, 63) == 0)
                    begin
                        send_calm = $urandom_range(30, 120);
                        send_wait = 0;
                    end
                    else
                        send_wait = idle_length();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side backpressure: random stall runs, with calm stretches
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned stall_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (stall_calm != 0)
                stall_calm--;
            else if ($urandom_range(0, 63) == 0)
                stall_calm = $urandom_range(30, 120);
            else
                stall_left = idle_length();
        end
    end

    // ------------------------------------------------------------------
    // Response checker: each accepted beat against the oldest answer owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rrlt_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("response beat with nothing owed: status %0d granted_id %0d",
                       rsp.status, rsp.granted_id);
                mismatch_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.granted_id !== want.granted_id)
                begin
                    $error("granted_id: expected %0d, got %0d", want.granted_id,
                           rsp.granted_id);
                    mismatch_count++;
                end
                answer_tally[want.status]++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timed out with %0d beats unsent and %0d answers owed",
                   pending_reqs.size(), expected_answers.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        coord_t      lx;
        coord_t      ty;
        coord_t      rx;
        coord_t      by;
        int unsigned unlock_pct;
        int unsigned pick;
        int unsigned shape;

        // Directed: extremes, read/write sharing rules, bad ids,
        // inverted rectangles, full table and conflict on a full table.
        queue_lock(1'b1, '0, '0, '1, '1);                // whole plane, write -> id 1
        queue_lock(1'b0, 32'd5, 32'd5, 32'd6, 32'd6);    // read under a write -> conflict
        queue_unlock(1);                                  // unlocked
        queue_unlock(17);                                 // above table -> not found
        queue_unlock(31);                                 // all id bits set -> not found
        queue_lock(1'b1, 32'd100, 32'd100, 32'd50, 32'd50);   // inverted write -> id 1
        queue_lock(1'b0, 32'd60, 32'd60, 32'd70, 32'd70);     // meets inverted span
        queue_lock(1'b0, 32'd200, 32'd0, 32'd300, 32'd10);    // misses it -> id 2
        // overlapping reads near the top of the range share: ids 3..16
        for (int i = 0; i < SLOTS - 2; i++)
            queue_lock(1'b0, '1 - coord_t'(i), '1 - coord_t'(2 * i), '1, '1);
        queue_lock(1'b0, 32'd0, 32'd1000, 32'd0, 32'd1000);   // no clash, full
        queue_lock(1'b1, '1, '1, '1, '1);                // clash reported over full
        queue_unlock(0);                                  // id zero -> not found
        queue_unlock(9);
        queue_lock(1'b1, '0, '0, '0, '0);                // reuses id 9

        // Random: phases with different unlock pressure so the table swings
        // between nearly empty and full. Most locks land in a small field
        // so overlaps are common; a few are inverted, wild or near the top.
        for (int phase = 0; phase < RANDOM_BEATS / 200; phase++)
        begin
            unlock_pct = $urandom_range(15, 60);
            for (int n = 0; n < 200; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < unlock_pct)
                    queue_unlock($urandom_range(1, SLOTS));
                else if (pick < unlock_pct + 4)
                    queue_unlock($urandom_range(0, 31));
                else
                begin
                    shape = $urandom_range(0, 19);
                    if (shape < 15)
                    begin
                        lx = $urandom_range(0, 127);
                        ty = $urandom_range(0, 127);
                        rx = lx + $urandom_range(0, 15);
                        by = ty + $urandom_range(0, 15);
                    end
                    else if (shape < 17)
                    begin
                        lx = $urandom_range(16, 143);
                        ty = $urandom_range(0, 127);
                        rx = lx - $urandom_range(1, 16);
                        by = ty + $urandom_range(0, 15);
                        if (shape == 16)
                            by = ty - $urandom_range(0, 16);
                    end
                    else if (shape < 19)
                    begin
                        lx = $urandom;
                        ty = $urandom;
                        rx = $urandom;
                        by = $urandom;
                    end
                    else
                    begin
                        lx = '1 - coord_t'($urandom_range(0, 63));
                        ty = '1 - coord_t'($urandom_range(0, 63));
                        rx = '1 - coord_t'($urandom_range(0, 31));
                        by = '1 - coord_t'($urandom_range(0, 31));
                    end
                    queue_lock(1'($urandom_range(0, 2) == 0), lx, ty, rx, by);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // all beats accepted, then every answer in, then a quiet tail
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d lock and %0d unlock beats under random idle and stall.",
                 lock_beats, unlock_beats);
        $display("Answers: %0d granted, %0d conflict, %0d full, %0d unlocked, %0d not found.",
                 answer_tally[ST_GRANTED], answer_tally[ST_CONFLICT], answer_tally[ST_FULL],
                 answer_tally[ST_UNLOCKED], answer_tally[ST_NOT_FOUND]);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/rrlt_pkg.sv
rtl/rrlt_cell.sv
rtl/rectangle_region_lock_table.sv
tb/sv/tb_rectangle_region_lock_table.sv
